[hdl/u8ed_pkg.sv]
// constants and types for the utf-8 / gbk encoding detector
// no dependencies
package u8ed_pkg;

	localparam int OUT_W     = 13;
	localparam int BAD_RATIO = 10;

	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_VAL  = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_VAL  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_VAL  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_VAL  = 8'hF0;
	localparam logic [7:0] BOM_0 = 8'hEF;
	localparam logic [7:0] BOM_1 = 8'hBB;
	localparam logic [7:0] BOM_2 = 8'hBF;

	localparam logic [1:0] POS_FULL = 2'd3;

	typedef struct packed {
		logic             encoding;
		logic             bom_found;
		logic [OUT_W-1:0] checked_count;
		logic [OUT_W-1:0] bad_count;
	} result_t;

	function automatic logic [7:0] bom_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = BOM_0;
			2'd1:    b = BOM_1;
			default: b = BOM_2;
		endcase
		return b;
	endfunction

endpackage

[hdl/u8ed_tracker.sv]
// per-byte sequence tracking, saturating counters and verdict
// depends on u8ed_pkg
module u8ed_tracker import u8ed_pkg::*; #(
	parameter int SAMPLE_BYTES = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] text_byte,
	input  logic       last_byte,
	output result_t    result
);

	localparam int CW = $clog2(SAMPLE_BYTES + 1);
	localparam logic [CW-1:0] SAT = CW'(SAMPLE_BYTES);

	logic [1:0]    pend_q, pend_n;
	logic          sbad_q, sbad_n;
	logic [CW-1:0] chk_q, chk_n;
	logic [CW-1:0] bad_q, bad_n;
	logic [1:0]    pos_q, pos_n;
	logic          bom_q, bom_n;
	logic [CW+3:0] bad_x10;
	logic          bom;

	always_comb begin
		pend_n = pend_q;
		sbad_n = sbad_q;
		chk_n  = chk_q;
		bad_n  = bad_q;
		pos_n  = pos_q;
		bom_n  = bom_q;

		if (pos_q != POS_FULL) begin
			if (text_byte != bom_byte(pos_q)) begin
				bom_n = 1'b0;
			end
			pos_n = pos_q + 2'd1;
		end

		if (pend_q != 2'd0) begin
			if ((text_byte & CONT_MASK) != CONT_VAL) begin
				sbad_n = 1'b1;
			end
			pend_n = pend_q - 2'd1;
			if (pend_n == 2'd0) begin
				if (sbad_n && bad_q < SAT) begin
					bad_n = bad_q + CW'(1);
				end
				sbad_n = 1'b0;
			end
		end else if (text_byte[7]) begin
			if (chk_q < SAT) begin
				chk_n = chk_q + CW'(1);
			end
			if ((text_byte & LEAD2_MASK) == LEAD2_VAL) begin
				pend_n = 2'd1;
			end else if ((text_byte & LEAD3_MASK) == LEAD3_VAL) begin
				pend_n = 2'd2;
			end else if ((text_byte & LEAD4_MASK) == LEAD4_VAL) begin
				pend_n = 2'd3;
			end else if (bad_q < SAT) begin
				bad_n = bad_q + CW'(1);
			end
			sbad_n = 1'b0;
		end
	end

	// bad * 10 as shifts
	assign bad_x10 = {1'b0, bad_n, 3'b000} + {3'b000, bad_n, 1'b0};
	assign bom     = bom_n && (pos_n == POS_FULL);

	always_comb begin
		result.bom_found     = bom;
		result.encoding      = !bom && (chk_n != '0) &&
			!(bad_x10 < (CW+4)'(chk_n));
		result.checked_count = OUT_W'(chk_n);
		result.bad_count     = OUT_W'(bad_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sbad_q <= 1'b0;
			chk_q  <= '0;
			bad_q  <= '0;
			pos_q  <= '0;
			bom_q  <= 1'b1;
		end else if (step) begin
			if (last_byte) begin
				pend_q <= '0;
				sbad_q <= 1'b0;
				chk_q  <= '0;
				bad_q  <= '0;
				pos_q  <= '0;
				bom_q  <= 1'b1;
			end else begin
				pend_q <= pend_n;
				sbad_q <= sbad_n;
				chk_q  <= chk_n;
				bad_q  <= bad_n;
				pos_q  <= pos_n;
				bom_q  <= bom_n;
			end
		end
	end

endmodule

[hdl/utf8_encoding_detector.sv]
// utf-8 / gbk encoding detector, top level
// input register, tracker and result register; depends on u8ed_pkg, u8ed_tracker
//
// usage: sample bytes arrive on the byte channel (byte_valid / byte_ready,
// text_byte, last_byte), one transfer per byte, last_byte high on the final
// byte of a sample. one verdict per sample leaves on the result channel
// (result_valid / result_ready, encoding, bom_found, checked_count, bad_count).
// throughput: one byte per cycle, except while a final byte waits behind a held verdict.
// a final byte's verdict passes the input register, then the result register.
// the next sample may start on the cycle after a final byte; no gap needed.
// when the receiver stalls, a held verdict blocks only a second final byte;
// non-final bytes keep flowing through the tracker.
// reset clears the pipeline and starts a fresh sample; counters saturate
// at SAMPLE_BYTES and are reported in 13 bits.
module utf8_encoding_detector import u8ed_pkg::*; #(
	parameter int SAMPLE_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_ready,
	input  logic [7:0]       text_byte,
	input  logic             last_byte,
	output logic             result_valid,
	input  logic             result_ready,
	output logic             encoding,
	output logic             bom_found,
	output logic [OUT_W-1:0] checked_count,
	output logic [OUT_W-1:0] bad_count
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	result_t    res;
	result_t    res_q;

	assign adv        = valid_s1 && (!last_s1 || !result_valid || result_ready);
	assign byte_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	u8ed_tracker #(
		.SAMPLE_BYTES(SAMPLE_BYTES)
	) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.result    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv && last_s1) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			res_q <= res;
		end
	end

	assign encoding      = res_q.encoding;
	assign bom_found     = res_q.bom_found;
	assign checked_count = res_q.checked_count;
	assign bad_count     = res_q.bad_count;

endmodule
